>>> src/ntcu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntcu_pkg
// Conversion codes and shared types for the numeric type conversion unit.
// ----------------------------------------------------------------------------
package ntcu_pkg;

	typedef enum logic [3:0] {
		FN_I2L = 4'd0,  FN_I2F = 4'd1,  FN_I2D = 4'd2,  FN_L2I = 4'd3,
		FN_L2F = 4'd4,  FN_L2D = 4'd5,  FN_F2I = 4'd6,  FN_F2L = 4'd7,
		FN_F2D = 4'd8,  FN_D2I = 4'd9,  FN_D2L = 4'd10, FN_D2F = 4'd11,
		FN_I2B = 4'd12, FN_I2C = 4'd13, FN_I2S = 4'd14, FN_NONE = 4'd15
	} func_t;

	typedef enum logic [1:0] {
		K_DIRECT = 2'd0,
		K_PACK   = 2'd1,
		K_TOINT  = 2'd2
	} kind_t;

	// Unpacked operand handed from the front stage to the later stages
	typedef struct packed {
		kind_t        kind;
		logic         sign;
		logic [63:0]  mag;      // integer magnitude or significand
		logic [12:0]  e;        // signed power of two of mag lsb
		logic         to_dbl;   // pack target is double
		logic         wide;     // integer target is 64 bits
		logic         over;     // forced saturation (infinity)
		logic [63:0]  direct;   // final bits for direct kinds
	} front_t;

endpackage

>>> src/ntcu_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntcu_core
// Four stage conversion datapath: unpack, leading-one search, align and round, pack.
// ----------------------------------------------------------------------------
module ntcu_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               in_valid,
	input  logic [3:0]         func,
	input  logic [63:0]        operand,
	output logic               out_valid,
	output logic [63:0]        result
);
	import ntcu_pkg::*;

	// ---------------- stage 1: unpack
	front_t f_c;
	logic [31:0] lo;
	always_comb begin
		lo = operand[31:0];
		f_c = '0;
		f_c.kind = K_DIRECT;
		unique case (func_t'(func))
			FN_I2L: f_c.direct = {{32{lo[31]}}, lo};
			FN_L2I: f_c.direct = {32'd0, lo};
			FN_I2B: f_c.direct = {32'd0, {24{lo[7]}}, lo[7:0]};
			FN_I2C: f_c.direct = {48'd0, lo[15:0]};
			FN_I2S: f_c.direct = {32'd0, {16{lo[15]}}, lo[15:0]};
			FN_I2F, FN_I2D: begin
				f_c.kind = K_PACK;
				f_c.sign = lo[31];
				f_c.mag = {32'd0, lo[31] ? (32'd0 - lo) : lo};
				f_c.to_dbl = (func_t'(func) == FN_I2D);
			end
			FN_L2F, FN_L2D: begin
				f_c.kind = K_PACK;
				f_c.sign = operand[63];
				f_c.mag = operand[63] ? (64'd0 - operand) : operand;
				f_c.to_dbl = (func_t'(func) == FN_L2D);
			end
			FN_F2I, FN_F2L, FN_F2D: begin
				f_c.sign = lo[31];
				f_c.mag = {40'd0, lo[30:23] != 8'd0, lo[22:0]};
				f_c.e = (lo[30:23] == 8'd0) ? -13'sd149
					: 13'({5'd0, lo[30:23]}) - 13'd150;
				f_c.wide = (func_t'(func) == FN_F2L);
				if (func_t'(func) == FN_F2D) begin
					f_c.kind = K_PACK;
					f_c.to_dbl = 1'b1;
					if (lo[30:23] == 8'hFF) begin
						f_c.kind = K_DIRECT;
						f_c.direct = {lo[31], 11'h7FF, lo[22:0] != 23'd0,
							lo[21:0], 29'd0};
						if (lo[22:0] == 23'd0) f_c.direct[51] = 1'b0;
					end
				end else begin
					f_c.kind = K_TOINT;
					f_c.over = (lo[30:23] == 8'hFF);
					if (lo[30:23] == 8'hFF && lo[22:0] != 23'd0) begin
						f_c.kind = K_DIRECT;
						f_c.direct = '0;
					end
				end
			end
			FN_D2I, FN_D2L, FN_D2F: begin
				f_c.sign = operand[63];
				f_c.mag = {11'd0, operand[62:52] != 11'd0, operand[51:0]};
				f_c.e = (operand[62:52] == 11'd0) ? -13'sd1074
					: 13'({2'd0, operand[62:52]}) - 13'd1075;
				f_c.wide = (func_t'(func) == FN_D2L);
				if (func_t'(func) == FN_D2F) begin
					f_c.kind = K_PACK;
					if (operand[62:52] == 11'h7FF) begin
						f_c.kind = K_DIRECT;
						f_c.direct = {32'd0, operand[63], 8'hFF,
							operand[51:29] | {(operand[51:0] != 52'd0), 22'd0}};
					end
				end else begin
					f_c.kind = K_TOINT;
					f_c.over = (operand[62:52] == 11'h7FF);
					if (operand[62:52] == 11'h7FF && operand[51:0] != 52'd0) begin
						f_c.kind = K_DIRECT;
						f_c.direct = '0;
					end
				end
			end
			default: f_c.direct = '0;
		endcase
	end

	front_t f_s1;
	logic   v_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			f_s1 <= f_c;
		end
	end

	// ---------------- stage 2: leading one position
	logic [5:0] p_c;
	always_comb begin
		p_c = '0;
		for (int i = 0; i < 64; i++) begin
			if (f_s1.mag[i]) p_c = 6'(i);
		end
	end

	front_t     f_s2;
	logic [5:0] p_s2;
	logic       v_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			f_s2 <= f_s1;
			p_s2 <= p_c;
		end
	end

	// ---------------- stage 3: align
	logic signed [13:0] biased_c, shift_c, bias_c, mb_c, pe_c;
	logic [63:0] q_c, ilim_c, imag_c;
	logic        rnd_c, ov_c;
	logic [64:0] frac_c;
	always_comb begin
		bias_c = f_s2.to_dbl ? 14'sd1023 : 14'sd127;
		mb_c = f_s2.to_dbl ? 14'sd52 : 14'sd23;
		pe_c = 14'($signed({8'd0, p_s2})) + 14'($signed(f_s2.e));
		biased_c = pe_c + bias_c;
		shift_c = 14'($signed({8'd0, p_s2})) - mb_c;
		if (biased_c < 14'sd1) begin
			shift_c = shift_c + 14'sd1 - biased_c;
			biased_c = 14'sd1;
		end
		q_c = '0;
		rnd_c = 1'b0;
		frac_c = '0;
		if (shift_c <= 0) begin
			q_c = f_s2.mag << (-shift_c);
		end else if (shift_c < 14'sd65) begin
			frac_c = {1'b0, f_s2.mag} << (7'd65 - 7'(shift_c));
			q_c = (shift_c < 14'sd64) ? (f_s2.mag >> shift_c) : 64'd0;
			rnd_c = frac_c[64] && ((frac_c[63:0] != 64'd0) || q_c[0]);
		end
		ov_c = f_s2.over;
		imag_c = '0;
		if (f_s2.e[12] == 1'b0) begin
			if (14'($signed({8'd0, p_s2})) + 14'sd1 + 14'($signed(f_s2.e))
				> (f_s2.wide ? 14'sd63 : 14'sd31)) ov_c = 1'b1;
			else imag_c = f_s2.mag << f_s2.e[5:0];
		end else if ($signed(f_s2.e) > -13'sd64) begin
			imag_c = f_s2.mag >> (-f_s2.e);
		end
		ilim_c = f_s2.wide ? {1'b0, {63{1'b1}}} : 64'h7FFF_FFFF;
		if (f_s2.sign) ilim_c = ilim_c + 64'd1;
	end

	front_t       f_s3;
	logic [63:0]  q_s3, imag_s3, ilim_s3;
	logic [13:0]  biased_s3;
	logic         ov_s3, v_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			f_s3 <= f_s2;
			q_s3 <= q_c + 64'(rnd_c);
			biased_s3 <= biased_c;
			imag_s3 <= imag_c;
			ilim_s3 <= ilim_c;
			ov_s3 <= ov_c;
		end
	end

	// ---------------- stage 4: pack
	logic [63:0] r_c, inf_c, bits_c, mg_c;
	always_comb begin
		r_c = '0;
		inf_c = f_s3.to_dbl ? {1'b0, 11'h7FF, 52'd0} : {33'd0, 8'hFF, 23'd0};
		bits_c = '0;
		mg_c = '0;
		unique case (f_s3.kind)
			K_DIRECT: r_c = f_s3.direct;
			K_PACK: begin
				if (f_s3.mag == 64'd0) begin
					bits_c = '0;
				end else if (biased_s3 - 14'sd1 >= (f_s3.to_dbl ? 14'sd2048 : 14'sd256)) begin
					bits_c = inf_c;
				end else begin
					bits_c = (f_s3.to_dbl ? (64'(biased_s3 - 14'sd1) << 52)
						: (64'(biased_s3 - 14'sd1) << 23)) + q_s3;
					if (bits_c >= inf_c) bits_c = inf_c;
				end
				r_c = f_s3.to_dbl ? ({f_s3.sign, 63'd0} | bits_c)
					: ({32'd0, f_s3.sign, 31'd0} | bits_c);
			end
			K_TOINT: begin
				mg_c = (ov_s3 || imag_s3 > ilim_s3) ? ilim_s3 : imag_s3;
				if (f_s3.mag == 64'd0) mg_c = '0;
				if (f_s3.sign) mg_c = 64'd0 - mg_c;
				r_c = f_s3.wide ? mg_c : {32'd0, mg_c[31:0]};
			end
			default: r_c = '0;
		endcase
	end

	logic v_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_s3;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			result <= r_c;
		end
	end
	assign out_valid = v_s4;

endmodule

>>> src/numeric_type_conversion_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// numeric_type_conversion_unit
// Java primitive conversions between int, long, float and double bit patterns,
// plus int to byte, char and short.
// Usage:
//   Input item on s_axis: tdata[3:0] = func, tdata[67:4] = operand, rest zero.
//   Result item on m_axis: tdata = 64-bit result bits.
//   One item is taken every cycle while the receiver does not stall. The
//   four register stages are unpack, leading-one search, align and round,
//   and pack.
//   When the receiver stalls the whole pipeline holds; s_axis_tready is
//   high whenever the output register is empty or being read.
//   Reset clears all valid bits; no item is in flight afterward.
//   Unused code 15 yields a zero result.
// ----------------------------------------------------------------------------
module numeric_type_conversion_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,   // func[3:0], operand[67:4], zero pad
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata    // result[63:0]
);
	import ntcu_pkg::*;

	logic adv;
	assign adv = m_axis_tready | ~m_axis_tvalid;
	assign s_axis_tready = adv;

	ntcu_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (s_axis_tvalid),
		.func      (s_axis_tdata[3:0]),
		.operand   (s_axis_tdata[67:4]),
		.out_valid (m_axis_tvalid),
		.result    (m_axis_tdata)
	);

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed under stall");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("ready low with empty output");

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the numeric type conversion unit. A directed table
// covers every conversion code with its extremes, NaN, infinity, zero,
// subnormal and saturation cases; random conversions follow, biased toward
// interesting exponents. Each result is compared against a bit-exact
// software converter kept in the bench, with random sender bursts and
// receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
	import ntcu_pkg::*;

	typedef struct {
		func_t       fn;
		logic [63:0] opnd;
		logic        known;
		logic [63:0] res;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [71:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [63:0] m_axis_tdata;

	logic [63:0] pending_results[$];
	int          errors;
	int          cycles;
	int          stall_phase;
	int          stall_mode;
	row_t        dir_rows[$];

	numeric_type_conversion_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	function automatic int msb_pos(logic [63:0] m);
		int p;
		p = 0;
		for (int i = 0; i < 64; i++)
			if (m[i]) p = i;
		return p;
	endfunction

	// round sign * m * 2^e to a binary format, nearest even
	function automatic logic [63:0] round_pack(logic sgn, logic [63:0] m, int e,
			int mb, int eb);
		logic [63:0] sbit, inf_bits, q, rem, half, bits;
		int p, bexp, sh, bias;
		bias = (1 << (eb - 1)) - 1;
		sbit = 64'(sgn) << (mb + eb);
		inf_bits = 64'((1 << eb) - 1) << mb;
		if (m == 0) return sbit;
		p = msb_pos(m);
		bexp = p + e + bias;
		sh = p - mb;
		if (bexp < 1) begin
			sh += 1 - bexp;
			bexp = 1;
		end
		if (sh <= 0) q = m << (-sh);
		else if (sh >= 65) q = 0;
		else begin
			q = (sh < 64) ? (m >> sh) : 64'd0;
			rem = (sh < 64) ? (m & ((64'd1 << sh) - 1)) : m;
			half = 64'd1 << (sh - 1);
			if (rem > half || (rem == half && q[0])) q++;
		end
		if (bexp - 1 >= (1 << eb)) return sbit | inf_bits;
		bits = (64'(bexp - 1) << mb) + q;
		if (bits >= inf_bits) bits = inf_bits;
		return sbit | bits;
	endfunction

	function automatic void split_fp(logic [63:0] x, int mb, int eb, output logic sgn,
			output logic [63:0] m, output int e, output int ef, output logic [63:0] fr);
		int bias;
		bias = (1 << (eb - 1)) - 1;
		fr = x & ((64'd1 << mb) - 1);
		ef = int'((x >> mb) & 64'((1 << eb) - 1));
		sgn = x[mb + eb];
		if (ef == 0) begin
			m = fr;
			e = 1 - bias - mb;
		end else begin
			m = fr | (64'd1 << mb);
			e = ef - bias - mb;
		end
	endfunction

	function automatic logic [63:0] fp_to_integer(logic [63:0] x, int mb, int eb, int w);
		logic sgn, over;
		logic [63:0] m, fr, mag, lim, wmask;
		int e, ef;
		over = 1'b0;
		wmask = (w >= 64) ? '1 : ((64'd1 << w) - 1);
		split_fp(x, mb, eb, sgn, m, e, ef, fr);
		if (ef == (1 << eb) - 1 && fr != 0) return 64'd0;
		if (ef == (1 << eb) - 1) over = 1'b1;
		if (m == 0) return 64'd0;
		if (e >= 0) begin
			if (msb_pos(m) + 1 + e > w - 1) begin
				over = 1'b1;
				mag = 0;
			end else mag = m << e;
		end else mag = (-e >= 64) ? 64'd0 : (m >> (-e));
		lim = 64'd1 << (w - 1);
		if (!sgn) lim -= 1;
		if (over || mag > lim) mag = lim;
		return (sgn ? (64'd0 - mag) : mag) & wmask;
	endfunction

	function automatic logic [63:0] integer_to_fp(logic [63:0] v, int w, int mb, int eb);
		logic [63:0] topb, mag;
		logic sgn;
		topb = 64'd1 << (w - 1);
		sgn = (v & topb) != 0;
		mag = v;
		if (w < 64) mag &= (topb << 1) - 1;
		if (sgn) mag = (w < 64) ? ((topb << 1) - mag) : (64'd0 - mag);
		return round_pack(sgn, mag, 0, mb, eb);
	endfunction

	function automatic logic [63:0] fp_resize(logic [63:0] x, int sm, int se, int dm, int de);
		logic sgn;
		logic [63:0] m, fr, sbit, inf_bits, f;
		int e, ef;
		split_fp(x, sm, se, sgn, m, e, ef, fr);
		sbit = 64'(sgn) << (dm + de);
		if (ef == (1 << se) - 1) begin
			inf_bits = 64'((1 << de) - 1) << dm;
			if (fr == 0) return sbit | inf_bits;
			f = (dm > sm) ? (fr << (dm - sm)) : (fr >> (sm - dm));
			return sbit | inf_bits | f | (64'd1 << (dm - 1));
		end
		return round_pack(sgn, m, e, dm, de);
	endfunction

	function automatic logic [63:0] convert(func_t fn, logic [63:0] op);
		logic [63:0] lo;
		lo = {32'd0, op[31:0]};
		case (fn)
			FN_I2L: return {{32{op[31]}}, op[31:0]};
			FN_I2F: return integer_to_fp(lo, 32, 23, 8);
			FN_I2D: return integer_to_fp(lo, 32, 52, 11);
			FN_L2I: return lo;
			FN_L2F: return integer_to_fp(op, 64, 23, 8);
			FN_L2D: return integer_to_fp(op, 64, 52, 11);
			FN_F2I: return fp_to_integer(lo, 23, 8, 32);
			FN_F2L: return fp_to_integer(lo, 23, 8, 64);
			FN_F2D: return fp_resize(lo, 23, 8, 52, 11);
			FN_D2I: return fp_to_integer(op, 52, 11, 32);
			FN_D2L: return fp_to_integer(op, 52, 11, 64);
			FN_D2F: return fp_resize(op, 52, 11, 23, 8);
			FN_I2B: return {32'd0, {24{op[7]}}, op[7:0]};
			FN_I2C: return {48'd0, op[15:0]};
			FN_I2S: return {32'd0, {16{op[15]}}, op[15:0]};
			default: return 64'd0;
		endcase
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// random operand with exponents clustered near the integer boundaries
	function automatic logic [63:0] random_operand(func_t fn);
		logic [63:0] v;
		v = rand64();
		case ($urandom_range(0, 3))
			0: ;
			1: if (fn inside {FN_F2I, FN_F2L, FN_F2D})
				v[30:23] = 8'($urandom_range(110, 200));
			else if (fn inside {FN_D2I, FN_D2L, FN_D2F})
				v[62:52] = 11'($urandom_range(860, 1100));
			else v = v >> $urandom_range(0, 63);
			2: if (fn inside {FN_F2I, FN_F2L, FN_F2D})
				v[30:23] = ($urandom_range(0, 1)) ? 8'hFF : 8'h00;
			else if (fn inside {FN_D2I, FN_D2L, FN_D2F})
				v[62:52] = ($urandom_range(0, 1)) ? 11'h7FF : 11'h000;
			else v = ~(v >> $urandom_range(0, 63));
			default: v = v & ~((64'd2 << $urandom_range(0, 40)) - 64'd1);
		endcase
		return v;
	endfunction

	task automatic send_item(func_t fn, logic [63:0] op, logic known, logic [63:0] res);
		s_axis_tdata <= {4'd0, op, fn};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		pending_results.push_back(convert(fn, op));
		if (known && convert(fn, op) !== res) begin
			$error("result: fn %s op %h expected %h actual %h", fn.name(), op, res,
				convert(fn, op));
			errors++;
		end
		@(negedge clk);
	endtask

	task automatic idle_gap();
		s_axis_tvalid <= 1'b0;
		repeat ($urandom_range(1, 6)) @(negedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				$error("result: unexpected item %h", m_axis_tdata);
				errors++;
			end else begin
				if (m_axis_tdata !== pending_results[0]) begin
					$error("result: expected %h actual %h", pending_results[0], m_axis_tdata);
					errors++;
				end
				void'(pending_results.pop_front());
			end
		end
	end

	always @(negedge clk) begin
		stall_phase++;
		if (stall_phase % 200 == 0) stall_mode = $urandom_range(0, 2);
		case (stall_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= (stall_phase % 7) < 4;
			default: m_axis_tready <= $urandom_range(0, 2) != 0;
		endcase
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 200000) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		func_t fn;
		int burst;
		errors = 0;
		cycles = 0;
		stall_phase = 0;
		stall_mode = 0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;

		dir_rows = '{
			'{FN_I2L, 64'hFFFF_FFFF_8000_0000, 1, 64'hFFFF_FFFF_8000_0000},
			'{FN_I2L, 64'h0000_0000_7FFF_FFFF, 1, 64'h0000_0000_7FFF_FFFF},
			'{FN_I2F, 64'h0000_0000_8000_0000, 1, 64'h0000_0000_CF00_0000},
			'{FN_I2F, 64'h0000_0000_7FFF_FFFF, 0, 64'd0},
			'{FN_I2D, 64'h0000_0000_FFFF_FFFF, 1, 64'hBFF0_0000_0000_0000},
			'{FN_L2I, 64'hFFFF_FFFF_1234_5678, 1, 64'h0000_0000_1234_5678},
			'{FN_L2F, 64'h8000_0000_0000_0000, 1, 64'h0000_0000_DF00_0000},
			'{FN_L2F, 64'h7FFF_FFFF_FFFF_FFFF, 0, 64'd0},
			'{FN_L2D, 64'h0000_0000_0000_0000, 1, 64'd0},
			'{FN_L2D, 64'h0020_0000_0000_0003, 0, 64'd0},
			'{FN_F2I, 64'h0000_0000_7FC0_0000, 1, 64'd0},
			'{FN_F2I, 64'h0000_0000_FF80_0000, 1, 64'h0000_0000_8000_0000},
			'{FN_F2I, 64'h0000_0000_4F00_0000, 1, 64'h0000_0000_7FFF_FFFF},
			'{FN_F2L, 64'h0000_0000_7F80_0000, 1, 64'h7FFF_FFFF_FFFF_FFFF},
			'{FN_F2L, 64'h0000_0000_BFC0_0000, 1, 64'hFFFF_FFFF_FFFF_FFFF},
			'{FN_F2D, 64'h0000_0000_FF80_0001, 1, 64'hFFF8_0000_2000_0000},
			'{FN_F2D, 64'h0000_0000_0000_0001, 0, 64'd0},
			'{FN_D2I, 64'hC1E0_0000_0020_0000, 1, 64'h0000_0000_8000_0000},
			'{FN_D2L, 64'h7FF0_0000_0000_0001, 1, 64'd0},
			'{FN_D2L, 64'hFFF0_0000_0000_0000, 1, 64'h8000_0000_0000_0000},
			'{FN_D2F, 64'h7FF0_0000_2000_0000, 1, 64'h0000_0000_7FC0_0001},
			'{FN_D2F, 64'h47EF_FFFF_F000_0000, 1, 64'h0000_0000_7F80_0000},
			'{FN_D2F, 64'h8000_0000_0000_0001, 1, 64'h0000_0000_8000_0000},
			'{FN_I2B, 64'hFFFF_FFFF_FFFF_FF80, 1, 64'h0000_0000_FFFF_FF80},
			'{FN_I2C, 64'hFFFF_FFFF_FFFF_8001, 1, 64'h0000_0000_0000_8001},
			'{FN_I2S, 64'h0000_0000_0000_8000, 1, 64'h0000_0000_FFFF_8000},
			'{FN_NONE, 64'hFFFF_FFFF_FFFF_FFFF, 1, 64'd0}
		};

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_rows[i]) begin
			send_item(dir_rows[i].fn, dir_rows[i].opnd, dir_rows[i].known, dir_rows[i].res);
			if ($urandom_range(0, 3) == 0) idle_gap();
		end

		for (int n = 0; n < 1100; ) begin
			burst = $urandom_range(1, 40);
			if (n < 550 && n + burst > 550) burst = 550 - n;
			for (int k = 0; k < burst && n < 1100; k++, n++) begin
				fn = func_t'($urandom_range(0, 15));
				send_item(fn, random_operand(fn), 1'b0, 64'd0);
			end
			if (n == 550) begin
				s_axis_tvalid <= 1'b0;
				while (pending_results.size() != 0) @(negedge clk);
			end else if ($urandom_range(0, 2) != 0) idle_gap();
		end
		s_axis_tvalid <= 1'b0;

		while (pending_results.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
